>>> rtl/core/scpg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scpg_pkg: shared types and constants
// Field widths, generator constants, request codes and the sequencer state
// type for the seeded cyclic permutation generator.
// ----------------------------------------------------------------------------
package scpg_pkg;

  // Port field widths.
  localparam int SEED_W  = 31;
  localparam int INDEX_W = 11;
  localparam int ENTRY_W = 11;
  localparam int CFG_W   = 12;

  // Store depth; the index and entry widths above are sized for it.
  localparam int MAX_LEN = 2048;

  // Length register value after reset.
  localparam logic [CFG_W-1:0] LEN_RESET = 12'd2048;

  // Minstd generator: x' = x * 48271 mod (2^31 - 1).
  localparam int MUL_W     = 16;
  localparam int MUL_CNT_W = 5;
  localparam logic [MUL_W-1:0]  LCG_MULT = 16'd48271;
  localparam logic [SEED_W-1:0] LCG_MOD  = 31'h7FFF_FFFF;

  // Serial remainder: one dividend bit per cycle.
  localparam int DIV_CNT_W = 5;

  // Request codes.
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_MUL,
    ST_MOD,
    ST_RD_I,
    ST_RD_R,
    ST_WR_I,
    ST_WR_R
  } state_e;

endpackage
`default_nettype wire

>>> rtl/core/scpg_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scpg_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module scpg_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> rtl/core/scpg_lcg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scpg_lcg: bit-serial minstd generator
// Holds the generator value and advances it by a modular multiply that
// consumes one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module scpg_lcg (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       load_i,
  input  wire logic [scpg_pkg::SEED_W-1:0] seed_i,
  input  wire logic                       step_i,
  output logic      [scpg_pkg::SEED_W-1:0] value_o,
  output logic                            done_o
);

  logic [scpg_pkg::SEED_W-1:0]    val_q, acc_q, acc_d;
  logic [scpg_pkg::MUL_W-1:0]     sr_q;
  logic [scpg_pkg::MUL_CNT_W-1:0] cnt_q;
  logic                           run_q, done_q;
  logic [scpg_pkg::SEED_W-1:0]    rot, addend;
  logic [scpg_pkg::SEED_W:0]      sum;
  logic                           last;

  // Doubling mod 2^31-1 is a rotate; then add the operand if the bit is set.
  always_comb begin
    rot    = {acc_q[scpg_pkg::SEED_W-2:0], acc_q[scpg_pkg::SEED_W-1]};
    addend = sr_q[scpg_pkg::MUL_W-1] ? val_q : '0;
    sum    = {1'b0, rot} + {1'b0, addend};
    if (sum >= {1'b0, scpg_pkg::LCG_MOD}) begin
      acc_d = scpg_pkg::SEED_W'(sum - {1'b0, scpg_pkg::LCG_MOD});
    end else begin
      acc_d = sum[scpg_pkg::SEED_W-1:0];
    end
  end

  assign last = run_q && (cnt_q == scpg_pkg::MUL_CNT_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q  <= '0;
      acc_q  <= '0;
      sr_q   <= '0;
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= last;
      if (load_i) begin
        val_q <= seed_i;
      end else if (step_i) begin
        acc_q <= '0;
        sr_q  <= scpg_pkg::LCG_MULT;
        cnt_q <= scpg_pkg::MUL_CNT_W'(scpg_pkg::MUL_W);
        run_q <= 1'b1;
      end else if (run_q) begin
        acc_q <= acc_d;
        sr_q  <= {sr_q[scpg_pkg::MUL_W-2:0], 1'b0};
        cnt_q <= cnt_q - scpg_pkg::MUL_CNT_W'(1);
        if (last) begin
          val_q <= acc_d;
          run_q <= 1'b0;
        end
      end
    end
  end

  assign value_o = val_q;
  assign done_o  = done_q;

endmodule
`default_nettype wire

>>> rtl/core/scpg_mod.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scpg_mod: bit-serial remainder
// Restoring division that shifts in one dividend bit per cycle and keeps
// only the remainder.
// ----------------------------------------------------------------------------
module scpg_mod #(
  parameter int AW = 11
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [scpg_pkg::SEED_W-1:0] dividend_i,
  input  wire logic [AW-1:0]               divisor_i,
  output logic      [AW-1:0]               rem_o,
  output logic                             done_o
);

  logic [scpg_pkg::SEED_W-1:0]    sr_q;
  logic [AW-1:0]                  rem_q, rem_d;
  logic [scpg_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                           run_q, done_q;
  logic [AW:0]                    trial;
  logic                           last;

  always_comb begin
    trial = {rem_q, sr_q[scpg_pkg::SEED_W-1]};
    if (trial >= {1'b0, divisor_i}) begin
      rem_d = AW'(trial - {1'b0, divisor_i});
    end else begin
      rem_d = trial[AW-1:0];
    end
  end

  assign last = run_q && (cnt_q == scpg_pkg::DIV_CNT_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_q   <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= last;
      if (start_i) begin
        sr_q  <= dividend_i;
        rem_q <= '0;
        cnt_q <= scpg_pkg::DIV_CNT_W'(scpg_pkg::SEED_W);
        run_q <= 1'b1;
      end else if (run_q) begin
        sr_q  <= {sr_q[scpg_pkg::SEED_W-2:0], 1'b0};
        rem_q <= rem_d;
        cnt_q <= cnt_q - scpg_pkg::DIV_CNT_W'(1);
        if (last) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule
`default_nettype wire

>>> rtl/core/seeded_cyclic_permutation_gen_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seeded_cyclic_permutation_gen_top: seeded single-cycle permutation store
// Builds a pseudo-random cyclic permutation of 0..L-1 from a seed with a
// swap-with-lower shuffle driven by a minstd generator, then answers reads.
//
// Channel   Direction  Handshake                     Beat payload
// -------   ---------  ----------------------------  ------------------------
// request   in         start & !busy                 req_type_i, seed_i, index_i
// result    out        entry_valid_o (one cycle)     entry_o
// config    in         cfg_valid_i & cfg_ready_o     cfg_data_i (perm_length)
//
// A read beat's result strobes in the next cycle; reads may follow back to
// back. A start fills the identity, then runs L-1 swaps, each a multiply, a
// remainder and a swap (read i, read r, write i, write r).
// busy holds over the whole start; config waits while start is high or busy.
// Reset clears control state only; the store is undefined until a start.
// The receiver cannot stall: every result shows for exactly one cycle.
// ----------------------------------------------------------------------------
module seeded_cyclic_permutation_gen_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // request
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         req_type_i,
  input  wire logic [scpg_pkg::SEED_W-1:0]  seed_i,
  input  wire logic [scpg_pkg::INDEX_W-1:0] index_i,
  // result
  output logic                              entry_valid_o,
  output logic      [scpg_pkg::ENTRY_W-1:0] entry_o,
  // config
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [scpg_pkg::CFG_W-1:0]   cfg_data_i
);

  // Store address width, length width and a compare width wide enough for
  // the length register, the clamped length and the read index.
  localparam int AW = $clog2(scpg_pkg::MAX_LEN);
  localparam int LW = $clog2(scpg_pkg::MAX_LEN + 1);
  localparam int CW = (LW > scpg_pkg::CFG_W) ? LW : scpg_pkg::CFG_W;

  scpg_pkg::state_e state_q, state_d;

  logic [scpg_pkg::CFG_W-1:0] len_q;
  logic [AW-1:0]              fill_q, pos_q, vali_q;
  logic                       strobe_q;

  logic [CW-1:0] len_ext, eff_ext, idx_ext;
  logic [AW-1:0] last_idx, rd_idx;
  logic          accept, acc_start, acc_read;

  // Control from the sequencer.
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_wdata, ram_raddr, ram_rdata;
  logic          lcg_load, lcg_step, div_start;
  logic          fill_clr, fill_inc, pos_load, pos_dec, cap_vali;

  logic [scpg_pkg::SEED_W-1:0] lcg_value;
  logic                        lcg_done;
  logic [AW-1:0]               div_rem;
  logic                        div_done;

  // Clamp the length to 1..MAX_LEN; a read past the end saturates.
  always_comb begin
    len_ext = CW'(len_q);
    if (len_ext == '0) begin
      eff_ext = CW'(1);
    end else if (len_ext > CW'(scpg_pkg::MAX_LEN)) begin
      eff_ext = CW'(scpg_pkg::MAX_LEN);
    end else begin
      eff_ext = len_ext;
    end
    last_idx = AW'(eff_ext - CW'(1));
    idx_ext  = CW'(index_i);
    rd_idx   = (idx_ext >= eff_ext) ? last_idx : AW'(idx_ext);
  end

  assign busy      = (state_q != scpg_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign acc_start = accept && (req_type_i == scpg_pkg::REQ_START);
  assign acc_read  = accept && (req_type_i == scpg_pkg::REQ_READ);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      scpg_pkg::ST_IDLE: begin
        if (acc_start) state_d = scpg_pkg::ST_FILL;
      end
      scpg_pkg::ST_FILL: begin
        if (fill_q == last_idx) begin
          state_d = (last_idx == '0) ? scpg_pkg::ST_IDLE : scpg_pkg::ST_MUL;
        end
      end
      scpg_pkg::ST_MUL: begin
        if (lcg_done) state_d = scpg_pkg::ST_MOD;
      end
      scpg_pkg::ST_MOD: begin
        if (div_done) state_d = scpg_pkg::ST_RD_I;
      end
      scpg_pkg::ST_RD_I: state_d = scpg_pkg::ST_RD_R;
      scpg_pkg::ST_RD_R: state_d = scpg_pkg::ST_WR_I;
      scpg_pkg::ST_WR_I: state_d = scpg_pkg::ST_WR_R;
      scpg_pkg::ST_WR_R: begin
        state_d = (pos_q == AW'(1)) ? scpg_pkg::ST_IDLE : scpg_pkg::ST_MUL;
      end
      default: state_d = scpg_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fill_q;
    ram_wdata = fill_q;
    ram_re    = 1'b0;
    ram_raddr = rd_idx;
    lcg_load  = 1'b0;
    lcg_step  = 1'b0;
    div_start = 1'b0;
    fill_clr  = 1'b0;
    fill_inc  = 1'b0;
    pos_load  = 1'b0;
    pos_dec   = 1'b0;
    cap_vali  = 1'b0;
    case (state_q)
      scpg_pkg::ST_IDLE: begin
        ram_re   = acc_read;
        lcg_load = acc_start;
        fill_clr = acc_start;
      end
      scpg_pkg::ST_FILL: begin
        // Write the identity, then kick off the first generator step.
        ram_we   = 1'b1;
        fill_inc = 1'b1;
        if ((fill_q == last_idx) && (last_idx != '0)) begin
          lcg_step = 1'b1;
          pos_load = 1'b1;
        end
      end
      scpg_pkg::ST_MUL: begin
        div_start = lcg_done;
      end
      scpg_pkg::ST_MOD: begin
      end
      scpg_pkg::ST_RD_I: begin
        ram_re    = 1'b1;
        ram_raddr = pos_q;
      end
      scpg_pkg::ST_RD_R: begin
        ram_re    = 1'b1;
        ram_raddr = div_rem;
        cap_vali  = 1'b1;
      end
      scpg_pkg::ST_WR_I: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = ram_rdata;
      end
      scpg_pkg::ST_WR_R: begin
        ram_we    = 1'b1;
        ram_waddr = div_rem;
        ram_wdata = vali_q;
        if (pos_q != AW'(1)) begin
          pos_dec  = 1'b1;
          lcg_step = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= scpg_pkg::ST_IDLE;
      len_q    <= scpg_pkg::LEN_RESET;
      fill_q   <= '0;
      pos_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= acc_read;
      if (cfg_valid_i && cfg_ready_o) begin
        len_q <= cfg_data_i;
      end
      if (fill_clr) begin
        fill_q <= '0;
      end else if (fill_inc) begin
        fill_q <= fill_q + AW'(1);
      end
      if (pos_load) begin
        pos_q <= last_idx;
      end else if (pos_dec) begin
        pos_q <= pos_q - AW'(1);
      end
    end
  end

  // Hold the entry read from position i while entry r comes back.
  always_ff @(posedge clk_i) begin
    if (cap_vali) begin
      vali_q <= ram_rdata;
    end
  end

  scpg_ram #(
    .WIDTH (AW),
    .DEPTH (scpg_pkg::MAX_LEN)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  scpg_lcg u_lcg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (lcg_load),
    .seed_i  (seed_i),
    .step_i  (lcg_step),
    .value_o (lcg_value),
    .done_o  (lcg_done)
  );

  scpg_mod #(
    .AW (AW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (lcg_value),
    .divisor_i  (pos_q),
    .rem_o      (div_rem),
    .done_o     (div_done)
  );

  // Hold off length writes while a request beat is offered, so a start never
  // sees the length change under it.
  assign cfg_ready_o   = !busy && !start;
  assign entry_valid_o = strobe_q;
  assign entry_o       = scpg_pkg::ENTRY_W'(ram_rdata);

`ifndef SYNTHESIS
  // A read result never lands while a start is in progress.
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_valid_o |-> !busy)
    else $error("result strobe during a start");

  // The swap partner is always below the swap position.
  a_rem_below_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == scpg_pkg::ST_RD_I) |-> (div_rem < pos_q))
    else $error("swap partner not below swap position");

  // Writes stay inside the active length.
  a_write_in_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (ram_waddr <= last_idx))
    else $error("store write beyond active length");

  // A finished multiply always hands over to the remainder unit.
  a_mul_to_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lcg_done && (state_q == scpg_pkg::ST_MUL)) |=> (state_q == scpg_pkg::ST_MOD))
    else $error("multiply done without remainder step");
`endif

endmodule
`default_nettype wire
